// File: hdl/blr_pkg.sv
// Shared types and constants of the Bresenham line rasterizer.
// Used by blr_ctrl, blr_datapath and bresenham_line_rasterizer; depends on nothing.
package blr_pkg;

	localparam int COORD_BITS = 6;
	localparam int GRID_BITS = 7;
	// Room for the doubled deltas plus a sign bit.
	localparam int ERR_BITS = COORD_BITS + 3;
	localparam logic [GRID_BITS-1:0] GRID_RESET = GRID_BITS'(30);

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [GRID_BITS-1:0] grid_t;
	typedef logic signed [ERR_BITS-1:0] err_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic emit;
	} blr_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic at_end;
		logic out_free;
	} blr_sts_t;

endpackage

// File: hdl/blr_ctrl.sv
// Controller state machine of the line rasterizer: accepts a segment, then
// paces the datapath one pixel per free output slot. Depends on blr_pkg.
module blr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  blr_pkg::blr_sts_t sts,
	output blr_pkg::blr_cmd_t cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic state_q;
	logic state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.at_end) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: hdl/blr_datapath.sv
// Datapath of the line rasterizer: octant setup, Bresenham walk registers,
// grid size register and the output register. Depends on blr_pkg.
module blr_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  blr_pkg::coord_t     start_x,
	input  blr_pkg::coord_t     start_y,
	input  blr_pkg::coord_t     end_x,
	input  blr_pkg::coord_t     end_y,
	input  logic                cfg_write,
	input  blr_pkg::grid_t      cfg_grid,
	input  blr_pkg::blr_cmd_t   cmd,
	output blr_pkg::blr_sts_t   sts,
	output logic                out_valid,
	input  logic                out_stall,
	output blr_pkg::coord_t     pixel_x,
	output blr_pkg::coord_t     pixel_y,
	output logic                inside_grid,
	output logic                last_pixel
);

	blr_pkg::grid_t  grid_q;
	blr_pkg::coord_t maj_q, mnr_q, end_q, dmaj_q, dmin_q;
	blr_pkg::err_t   err_q;
	logic            down_q, swap_q;
	logic            out_valid_q;
	blr_pkg::coord_t px_q, py_q;
	logic            inside_q, last_q;

	// Setup of a new segment.
	blr_pkg::coord_t dx_abs, dy_abs, a1, b1, a2, b2;
	blr_pkg::coord_t ma_lo, mi_lo, ma_hi, mi_hi, dmaj_c, dmin_c;
	logic            swap_c, rev_c, down_c;
	blr_pkg::err_t   err0_c;

	// Walk step.
	blr_pkg::err_t   twice_min, twice_maj, err_next;
	logic            err_pos;
	blr_pkg::coord_t cur_x, cur_y;

	always_comb begin
		dx_abs = (end_x > start_x) ? end_x - start_x : start_x - end_x;
		dy_abs = (end_y > start_y) ? end_y - start_y : start_y - end_y;
		swap_c = dy_abs > dx_abs;
		a1 = swap_c ? start_y : start_x;
		b1 = swap_c ? start_x : start_y;
		a2 = swap_c ? end_y : end_x;
		b2 = swap_c ? end_x : end_y;
		// Equal major coordinates keep the input order.
		rev_c = a2 < a1;
		ma_lo = rev_c ? a2 : a1;
		mi_lo = rev_c ? b2 : b1;
		ma_hi = rev_c ? a1 : a2;
		mi_hi = rev_c ? b1 : b2;
		dmaj_c = ma_hi - ma_lo;
		down_c = mi_hi < mi_lo;
		dmin_c = down_c ? mi_lo - mi_hi : mi_hi - mi_lo;
		err0_c = blr_pkg::err_t'({2'b00, dmin_c, 1'b0}) - blr_pkg::err_t'({3'b000, dmaj_c});
	end

	always_comb begin
		twice_min = blr_pkg::err_t'({2'b00, dmin_q, 1'b0});
		twice_maj = blr_pkg::err_t'({2'b00, dmaj_q, 1'b0});
		err_pos = !err_q[blr_pkg::ERR_BITS-1] && (err_q != '0);
		err_next = err_pos ? err_q + twice_min - twice_maj : err_q + twice_min;
		cur_x = swap_q ? mnr_q : maj_q;
		cur_y = swap_q ? maj_q : mnr_q;
	end

	assign sts.at_end = (maj_q == end_q);
	assign sts.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_q <= blr_pkg::GRID_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				grid_q <= cfg_grid;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			maj_q <= ma_lo;
			mnr_q <= mi_lo;
			end_q <= ma_hi;
			dmaj_q <= dmaj_c;
			dmin_q <= dmin_c;
			err_q <= err0_c;
			down_q <= down_c;
			swap_q <= swap_c;
		end else if (cmd.emit && !sts.at_end) begin
			maj_q <= maj_q + 1'b1;
			err_q <= err_next;
			if (err_pos) begin
				mnr_q <= down_q ? mnr_q - 1'b1 : mnr_q + 1'b1;
			end
		end
		if (cmd.emit) begin
			px_q <= cur_x;
			py_q <= cur_y;
			inside_q <= ({1'b0, cur_x} < grid_q) && ({1'b0, cur_y} < grid_q);
			last_q <= sts.at_end;
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_x = px_q;
	assign pixel_y = py_q;
	assign inside_grid = inside_q;
	assign last_pixel = last_q;

endmodule

// File: hdl/bresenham_line_rasterizer.sv
// Top level of the Bresenham line rasterizer, all eight octants.
// Joins blr_ctrl and blr_datapath; depends on blr_pkg.
//
//  Channel  Handshake             Payload
//  -------  --------------------  ------------------------------------------
//  in       in_valid / in_stall   start_x, start_y, end_x, end_y
//  out      out_valid / out_stall pixel_x, pixel_y, inside_grid, last_pixel
//  cfg      cfg_valid / cfg_ready grid_size
//
// A segment is loaded in a setup step, then walked one pixel per cycle while the output
// register is free, paced by the single walk unit in the datapath.
// The next segment is accepted as soon as the last pixel sits in the output register.
// A stalled output register holds the walk in place; no pixel is dropped.
// Reset restores grid_size to 30 and leaves the block idle with no output valid.
module bresenham_line_rasterizer (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  blr_pkg::coord_t start_x,
	input  blr_pkg::coord_t start_y,
	input  blr_pkg::coord_t end_x,
	input  blr_pkg::coord_t end_y,
	output logic            out_valid,
	input  logic            out_stall,
	output blr_pkg::coord_t pixel_x,
	output blr_pkg::coord_t pixel_y,
	output logic            inside_grid,
	output logic            last_pixel,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  blr_pkg::grid_t  grid_size
);

	blr_pkg::blr_cmd_t cmd;
	blr_pkg::blr_sts_t sts;

	assign cfg_ready = 1'b1;

	blr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	blr_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.start_x     (start_x),
		.start_y     (start_y),
		.end_x       (end_x),
		.end_y       (end_y),
		.cfg_write   (cfg_valid && cfg_ready),
		.cfg_grid    (grid_size),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.inside_grid (inside_grid),
		.last_pixel  (last_pixel)
	);

endmodule

// File: hdl/blr_checker.sv
// Port-level checks of the line rasterizer, bound to the top level.
// Depends on blr_pkg and bresenham_line_rasterizer.
module blr_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_stall,
	input logic            out_valid,
	input logic            out_stall,
	input blr_pkg::coord_t pixel_x,
	input blr_pkg::coord_t pixel_y,
	input logic            last_pixel
);

	// A stalled pixel stays on the output.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pixel_x) && $stable(pixel_y))
		else $error("stalled output pixel changed");

	// After an input transfer the block is busy with that segment.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after a segment transfer");

	// While a pixel that is not the last one is shown, its line is still in progress.
	a_no_accept_mid_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_pixel |-> in_stall)
		else $error("input open while a line is still being drawn");

	// The block only goes busy because a segment was taken.
	a_busy_needs_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid))
		else $error("input stall rose without a segment transfer");

endmodule

bind bresenham_line_rasterizer blr_checker u_blr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.pixel_x    (pixel_x),
	.pixel_y    (pixel_y),
	.last_pixel (last_pixel)
);

// File: tb/sv/line_pixel_checker.sv
`timescale 1ns / 1ps
// Pixel checker for the Bresenham line rasterizer: predicts every pixel of each
// accepted segment and compares the output stream against it. Depends on blr_pkg.
module line_pixel_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_stall,
	input  blr_pkg::coord_t start_x,
	input  blr_pkg::coord_t start_y,
	input  blr_pkg::coord_t end_x,
	input  blr_pkg::coord_t end_y,
	input  logic            out_valid,
	input  logic            out_stall,
	input  blr_pkg::coord_t pixel_x,
	input  blr_pkg::coord_t pixel_y,
	input  logic            inside_grid,
	input  logic            last_pixel,
	input  logic            cfg_valid,
	input  logic            cfg_ready,
	input  blr_pkg::grid_t  grid_size,
	output int              mismatches,
	output int              pixels_pending
);

	typedef struct packed {
		blr_pkg::coord_t x;
		blr_pkg::coord_t y;
		logic            in_grid;
		logic            last;
	} pixel_t;

	pixel_t         expected_pixels[$];
	blr_pkg::grid_t grid_copy;

	// Walks the segment the way the rasterizer does and queues each pixel.
	function automatic void trace_line(input blr_pkg::coord_t sx, input blr_pkg::coord_t sy,
			input blr_pkg::coord_t ex, input blr_pkg::coord_t ey);
		int     ax, ay, bx, by, t, span, rise, dir, err, maj, mnr;
		bit     steep;
		pixel_t p;
		ax = sx;
		ay = sy;
		bx = ex;
		by = ey;
		span = (bx > ax) ? bx - ax : ax - bx;
		rise = (by > ay) ? by - ay : ay - by;
		steep = rise > span;
		if (steep) begin
			t = ax; ax = ay; ay = t;
			t = bx; bx = by; by = t;
		end
		// Walk from the smaller major coordinate; ties keep the input order.
		if (bx < ax) begin
			t = ax; ax = bx; bx = t;
			t = ay; ay = by; by = t;
		end
		span = bx - ax;
		rise = by - ay;
		dir = 1;
		if (rise < 0) begin
			dir = -1;
			rise = -rise;
		end
		err = 2 * rise - span;
		maj = ax;
		mnr = ay;
		do begin
			p.x = blr_pkg::coord_t'(steep ? mnr : maj);
			p.y = blr_pkg::coord_t'(steep ? maj : mnr);
			p.in_grid = (p.x < grid_copy) && (p.y < grid_copy);
			p.last = (maj >= bx);
			expected_pixels = {expected_pixels, p};
			if (err <= 0) begin
				err += 2 * rise;
			end else begin
				err += 2 * (rise - span);
				mnr += dir;
			end
			maj++;
		end while (!p.last);
	endfunction

	function automatic int field_differs(input string field, input int want, input int got);
		if (want == got)
			return 0;
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		pixel_t want;
		int     errs;
		if (!arst_n) begin
			grid_copy <= blr_pkg::GRID_RESET;
			mismatches <= 0;
			pixels_pending <= 0;
			expected_pixels.delete();
		end else begin
			errs = 0;
			if (out_valid && !out_stall) begin
				if (expected_pixels.size() == 0) begin
					$display("%0t: unexpected pixel, expected none, actual (%0d,%0d)",
						$time, pixel_x, pixel_y);
					errs++;
				end else begin
					want = expected_pixels.pop_front();
					errs += field_differs("pixel_x", want.x, pixel_x);
					errs += field_differs("pixel_y", want.y, pixel_y);
					errs += field_differs("inside_grid", want.in_grid, inside_grid);
					errs += field_differs("last_pixel", want.last, last_pixel);
				end
			end
			if (cfg_valid && cfg_ready)
				grid_copy <= grid_size;
			if (in_valid && !in_stall)
				trace_line(start_x, start_y, end_x, end_y);
			mismatches <= mismatches + errs;
			pixels_pending <= expected_pixels.size();
		end
	end

endmodule

// File: tb/sv/bresenham_line_rasterizer_test.sv
`timescale 1ns / 1ps
// Top of the rasterizer testbench: drives segments and grid sizes, stalls the output,
// and reports the verdict. Depends on blr_pkg, line_pixel_checker and the rasterizer.
module bresenham_line_rasterizer_test;

	localparam int CYCLE_LIMIT = 400000;
	localparam int LINES_PER_PHASE = 27;
	localparam int PHASES = 7;

	logic            clk;
	logic            arst_n;
	logic            in_valid;
	logic            in_stall;
	blr_pkg::coord_t start_x, start_y, end_x, end_y;
	logic            out_valid;
	logic            out_stall = 1'b0;
	blr_pkg::coord_t pixel_x, pixel_y;
	logic            inside_grid;
	logic            last_pixel;
	logic            cfg_valid;
	logic            cfg_ready;
	blr_pkg::grid_t  grid_size;
	logic            calm;
	int              mismatches;
	int              pixels_pending;
	int              cycle_count = 0;

	bresenham_line_rasterizer dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
		.out_valid(out_valid), .out_stall(out_stall),
		.pixel_x(pixel_x), .pixel_y(pixel_y),
		.inside_grid(inside_grid), .last_pixel(last_pixel),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .grid_size(grid_size)
	);

	line_pixel_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
		.out_valid(out_valid), .out_stall(out_stall),
		.pixel_x(pixel_x), .pixel_y(pixel_y),
		.inside_grid(inside_grid), .last_pixel(last_pixel),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .grid_size(grid_size),
		.mismatches(mismatches), .pixels_pending(pixels_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_stall <= calm ? 1'b0 : ($urandom_range(99) < 19);
	end

	// Valid stays up after a transfer, save for random gaps outside calm phases, so back-to-back segments need no gap.
	task automatic send_line(input blr_pkg::coord_t sx, input blr_pkg::coord_t sy,
			input blr_pkg::coord_t ex, input blr_pkg::coord_t ey);
		in_valid <= 1'b1;
		start_x <= sx;
		start_y <= sy;
		end_x <= ex;
		end_y <= ey;
		do @(posedge clk); while (in_stall);
		if (!calm && $urandom_range(99) < 19) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
	endtask

	task automatic send_random_line;
		blr_pkg::coord_t sx, sy, ex, ey;
		sx = blr_pkg::coord_t'($urandom_range(63));
		sy = blr_pkg::coord_t'($urandom_range(63));
		ex = blr_pkg::coord_t'($urandom_range(63));
		ey = blr_pkg::coord_t'($urandom_range(63));
		case ($urandom_range(9))
			6, 7: begin
				ex = blr_pkg::coord_t'(sx + $urandom_range(8) - 4);
				ey = blr_pkg::coord_t'(sy + $urandom_range(8) - 4);
			end
			8: begin
				if ($urandom_range(1))
					ex = sx;
				else
					ey = sy;
			end
			9: begin
				// Diagonals in either direction, or a single point.
				ex = $urandom_range(1) ? blr_pkg::coord_t'(sx + sy - ey)
					: blr_pkg::coord_t'(sx - sy + ey);
				if ($urandom_range(3) == 0) begin
					ex = sx;
					ey = sy;
				end
			end
			default: ;
		endcase
		send_line(sx, sy, ex, ey);
	endtask

	task automatic wait_drained;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pixels_pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_grid(input blr_pkg::grid_t value);
		cfg_valid <= 1'b1;
		grid_size <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		blr_pkg::grid_t setting;
		arst_n = 1'b0;
		in_valid = 1'b0;
		start_x = '0;
		start_y = '0;
		end_x = '0;
		end_y = '0;
		cfg_valid = 1'b0;
		grid_size = blr_pkg::GRID_RESET;
		calm = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Points, axis-aligned and diagonal lines, every octant, and error ties.
		send_line(0, 0, 0, 0);
		send_line(63, 63, 63, 63);
		send_line(0, 0, 63, 0);
		send_line(63, 5, 0, 5);
		send_line(5, 0, 5, 63);
		send_line(7, 63, 7, 0);
		send_line(0, 0, 63, 63);
		send_line(63, 63, 0, 0);
		send_line(0, 63, 63, 0);
		send_line(63, 0, 0, 63);
		send_line(10, 10, 40, 20);
		send_line(10, 10, 20, 40);
		send_line(40, 20, 10, 10);
		send_line(20, 40, 10, 10);
		send_line(10, 40, 40, 30);
		send_line(10, 40, 20, 10);
		send_line(40, 30, 10, 40);
		send_line(20, 10, 10, 40);
		send_line(0, 0, 2, 1);
		send_line(4, 3, 0, 1);
		send_line(0, 63, 63, 62);
		send_line(29, 29, 31, 31);
		wait_drained();

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: setting = '0;
				1: setting = '1;
				2: setting = 1;
				3: setting = 64;
				4: setting = 63;
				default: setting = blr_pkg::grid_t'($urandom_range(127));
			endcase
			write_grid(setting);
			calm <= (phase == 3);
			for (int n = 0; n < LINES_PER_PHASE; n++)
				send_random_line();
			wait_drained();
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0 && pixels_pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
